@@ sv/bptc_pkg.sv @@
// ============================================================================
// bptc_pkg
// Shared types and constants for the barometric compensation core: item
// layouts of both channels and configuration register indexes.
// ============================================================================
package bptc_pkg;

    // Pressure result fraction bits (Q17.8 by default)
    localparam int PRESSURE_FRAC_BITS_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_CAL_1     = 3'd0,
        REG_TEMP_CAL_2     = 3'd1,
        REG_TEMP_CAL_3     = 3'd2,
        REG_PRESS_CAL_1    = 3'd3,
        REG_PRESS_CAL_2_3  = 3'd4,
        REG_PRESS_CAL_4_5  = 3'd5,
        REG_PRESS_CAL_6_7  = 3'd6,
        REG_PRESS_CAL_8_9  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] celsius_centi;
        logic signed [15:0] fahrenheit_centi;
        logic [24:0]        pressure_pa_q8;
        logic               pressure_invalid;
    } result_t;

    localparam logic signed [15:0] CELSIUS_MIN = -16'sd20000;
    localparam logic signed [15:0] CELSIUS_MAX = 16'sd20000;
    localparam logic [24:0]        PRESS_MAX   = 25'h1FFFFFF;

endpackage

@@ sv/baro_temp_pressure_compensation_core.sv @@
// ============================================================================
// baro_temp_pressure_compensation_core
// Fixed-point barometric compensation: raw temperature and pressure readings
// in, compensated temperature (0.01 degC / 0.01 degF) and pressure (Pa, Q8)
// out, using factory calibration words held in configuration registers.
// ============================================================================
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  -------------------------
//  sample    in         sample_valid / sample_stall  bptc_pkg::sample_t
//  result    out        result_valid / result_stall  bptc_pkg::result_t
//  cfg       in         cfg_write (no wait)          cfg_index, cfg_data
//
//  One item per cycle sustained while sample_stall is low. An accepted item
//  passes 56 pipeline stages, the first loaded at the accepting edge, then
//  the output register that drives result_valid; 36 of the stages are the
//  restoring divider, one quotient bit each, which sets the depth.
//  Reset clears the valid bits and the calibration registers only.
//  A two-entry output (result + skid) frees the pipe from result_stall:
//  sample_stall is the registered skid-full flag, and the whole pipe holds
//  while it is set.
//
module baro_temp_pressure_compensation_core #(
    parameter int PRESSURE_FRAC_BITS = bptc_pkg::PRESSURE_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  bptc_pkg::sample_t                sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output bptc_pkg::result_t                result,
    input  logic                             cfg_write,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bptc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bptc_pkg::*;

    // Final rounding shift from Q16 to the output fraction
    localparam int SH = 16 - PRESSURE_FRAC_BITS;
    localparam logic signed [45:0] RND_HALF = 46'sd1 <<< (SH - 1);

    // Stage map
    localparam int ST_AB    = 0;   // a, b
    localparam int ST_SQ    = 1;   // b*b, a*T2
    localparam int ST_BT3   = 2;   // b*b*T3
    localparam int ST_SUM   = 3;   // fine temperature sum (Q16)
    localparam int ST_TEMP  = 4;   // tf, degC, degF
    localparam int ST_H     = 5;   // h = tf - 128000
    localparam int ST_HH    = 6;   // h*h, h*P5, h*P2
    localparam int ST_HHP   = 7;   // h*h*P6, h*h*P3
    localparam int ST_ACC1  = 8;
    localparam int ST_ACC2  = 9;
    localparam int ST_NUM   = 10;  // numerator, P1*t
    localparam int ST_DEN   = 11;  // num*6250, divisor
    localparam int ST_MAG   = 12;  // magnitudes and sign
    localparam int ST_DINIT = 13;  // overflow check, remainder seed
    localparam int DIV_STEPS = 36;
    localparam int ST_DIV0  = ST_DINIT + 1;
    localparam int ST_P     = ST_DIV0 + DIV_STEPS;  // signed quotient
    localparam int ST_PSQ   = ST_P + 1;             // q*q, p*P8
    localparam int ST_SP9   = ST_P + 2;
    localparam int ST_W     = ST_P + 3;
    localparam int ST_FIN   = ST_P + 4;
    localparam int ST_RES   = ST_P + 5;
    localparam int NSTG     = ST_RES + 1;

    localparam logic signed [43:0] CC_LO = -44'sd20000;
    localparam logic signed [43:0] CC_HI = 44'sd20000;
    localparam logic signed [43:0] FC_LO = -44'sd32768;
    localparam logic signed [43:0] FC_HI = 44'sd32767;
    localparam logic signed [43:0] RND23 = 44'sd8388608;

    typedef struct packed {
        logic [19:0]        adc_p;
        logic signed [23:0] a;
        logic signed [20:0] b;
        logic [39:0]        bb;
        logic signed [39:0] at2;
        logic signed [56:0] bbt3;
        logic signed [38:0] sum;
        logic signed [22:0] tf;
        logic signed [15:0] cc;
        logic signed [15:0] fc;
        logic signed [23:0] h;
        logic signed [47:0] hh;
        logic signed [39:0] hp5;
        logic signed [39:0] hp2;
        logic signed [63:0] hhp6;
        logic signed [63:0] hhp3;
        logic signed [63:0] v2;
        logic signed [63:0] sacc;
        logic signed [44:0] t;
        logic signed [52:0] num;
        logic signed [61:0] p1t;
        logic signed [63:0] n6;
        logic signed [47:0] d;
        logic [63:0]        an;
        logic [47:0]        ad;
        logic               neg;
        logic               dz;
        logic               sat;
        logic [47:0]        rem;
        logic [35:0]        dvd;
        logic [35:0]        quo;
        logic signed [37:0] p;
        logic [59:0]        qq;
        logic signed [53:0] pp8;
        logic signed [61:0] sp9;
        logic signed [47:0] w;
        logic signed [44:0] fin;
        logic [24:0]        press;
    } ctx_t;

    // ---------------------------------------------------------------- config
    logic [15:0] temp_cal_1_reg, temp_cal_2_reg, temp_cal_3_reg, press_cal_1_reg;
    logic [31:0] press_cal_2_3_reg, press_cal_4_5_reg;
    logic [31:0] press_cal_6_7_reg, press_cal_8_9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_1_reg    <= '0;
            temp_cal_2_reg    <= '0;
            temp_cal_3_reg    <= '0;
            press_cal_1_reg   <= '0;
            press_cal_2_3_reg <= '0;
            press_cal_4_5_reg <= '0;
            press_cal_6_7_reg <= '0;
            press_cal_8_9_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TEMP_CAL_1:    temp_cal_1_reg    <= cfg_data[15:0];
                REG_TEMP_CAL_2:    temp_cal_2_reg    <= cfg_data[15:0];
                REG_TEMP_CAL_3:    temp_cal_3_reg    <= cfg_data[15:0];
                REG_PRESS_CAL_1:   press_cal_1_reg   <= cfg_data[15:0];
                REG_PRESS_CAL_2_3: press_cal_2_3_reg <= cfg_data;
                REG_PRESS_CAL_4_5: press_cal_4_5_reg <= cfg_data;
                REG_PRESS_CAL_6_7: press_cal_6_7_reg <= cfg_data;
                REG_PRESS_CAL_8_9: press_cal_8_9_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Calibration words; the user must keep them static while items are in flight (not enforced)
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [16:0] t1_s, p1_s;

    assign t1_s = $signed({1'b0, temp_cal_1_reg});
    assign p1_s = $signed({1'b0, press_cal_1_reg});
    assign t2   = $signed(temp_cal_2_reg);
    assign t3   = $signed(temp_cal_3_reg);
    assign p2   = $signed(press_cal_2_3_reg[15:0]);
    assign p3   = $signed(press_cal_2_3_reg[31:16]);
    assign p4   = $signed(press_cal_4_5_reg[15:0]);
    assign p5   = $signed(press_cal_4_5_reg[31:16]);
    assign p6   = $signed(press_cal_6_7_reg[15:0]);
    assign p7   = $signed(press_cal_6_7_reg[31:16]);
    assign p8   = $signed(press_cal_8_9_reg[15:0]);
    assign p9   = $signed(press_cal_8_9_reg[31:16]);

    // -------------------------------------------------------------- pipeline
    ctx_t    stg_reg  [NSTG];
    ctx_t    stg_next [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic    en;

    always_comb
    begin
        logic signed [41:0] b_sq;
        logic signed [38:0] neg_sum;
        logic signed [43:0] s44, c5, f9, cq, fq;
        logic [20:0]        base;
        logic [48:0]        trial;
        logic [36:0]        mag;
        logic signed [29:0] q8;
        logic signed [59:0] q_sq;
        logic [44:0]        s15;
        logic signed [45:0] rnd, rs;

        stg_next[0] = '0;
        for (int i = 1; i < NSTG; i++)
        begin
            stg_next[i] = stg_reg[i-1];
        end

        // a = adc_t*4 - T1*64 (Q16), b = adc_t - T1*16 (Q17)
        stg_next[ST_AB].adc_p = sample.raw_pressure;
        stg_next[ST_AB].a = $signed({2'b00, sample.raw_temperature, 2'b00})
                          - $signed({2'b00, temp_cal_1_reg, 6'b0});
        stg_next[ST_AB].b = $signed({1'b0, sample.raw_temperature})
                          - $signed({1'b0, temp_cal_1_reg, 4'b0});

        b_sq = stg_reg[ST_SQ-1].b * stg_reg[ST_SQ-1].b;
        stg_next[ST_SQ].bb  = b_sq[39:0];
        stg_next[ST_SQ].at2 = stg_reg[ST_SQ-1].a * t2;

        stg_next[ST_BT3].bbt3 = $signed({1'b0, stg_reg[ST_BT3-1].bb}) * t3;

        stg_next[ST_SUM].sum = 39'(stg_reg[ST_SUM-1].at2 + (stg_reg[ST_SUM-1].bbt3 >>> 18));

        // tf truncates toward zero; degC/degF round half up then clamp
        neg_sum = -stg_reg[ST_TEMP-1].sum;
        if (stg_reg[ST_TEMP-1].sum[38])
            stg_next[ST_TEMP].tf = -23'(neg_sum >>> 16);
        else
            stg_next[ST_TEMP].tf = 23'(stg_reg[ST_TEMP-1].sum >>> 16);
        s44 = 44'(stg_reg[ST_TEMP-1].sum);
        c5  = (s44 <<< 2) + s44 + RND23;
        f9  = (s44 <<< 3) + s44 + RND23;
        cq  = c5 >>> 24;
        fq  = (f9 >>> 24) + 44'sd3200;
        priority if (cq < CC_LO) stg_next[ST_TEMP].cc = 16'(CC_LO);
        else if (cq > CC_HI)     stg_next[ST_TEMP].cc = 16'(CC_HI);
        else                     stg_next[ST_TEMP].cc = 16'(cq);
        priority if (fq < FC_LO) stg_next[ST_TEMP].fc = 16'(FC_LO);
        else if (fq > FC_HI)     stg_next[ST_TEMP].fc = 16'(FC_HI);
        else                     stg_next[ST_TEMP].fc = 16'(fq);

        stg_next[ST_H].h = 24'(stg_reg[ST_H-1].tf) - 24'sd128000;

        stg_next[ST_HH].hh  = stg_reg[ST_HH-1].h * stg_reg[ST_HH-1].h;
        stg_next[ST_HH].hp5 = stg_reg[ST_HH-1].h * p5;
        stg_next[ST_HH].hp2 = stg_reg[ST_HH-1].h * p2;

        stg_next[ST_HHP].hhp6 = stg_reg[ST_HHP-1].hh * p6;
        stg_next[ST_HHP].hhp3 = stg_reg[ST_HHP-1].hh * p3;

        stg_next[ST_ACC1].v2   = (stg_reg[ST_ACC1-1].hhp6 >>> 1)
                               + (64'(stg_reg[ST_ACC1-1].hp5) <<< 16);
        stg_next[ST_ACC1].sacc = (stg_reg[ST_ACC1-1].hhp3 >>> 5)
                               + (64'(stg_reg[ST_ACC1-1].hp2) <<< 15);

        stg_next[ST_ACC2].v2 = (stg_reg[ST_ACC2-1].v2 >>> 2) + (64'(p4) <<< 32);
        stg_next[ST_ACC2].t  = 45'(stg_reg[ST_ACC2-1].sacc >>> 19);

        base = 21'h100000 - {1'b0, stg_reg[ST_NUM-1].adc_p};
        stg_next[ST_NUM].num = 53'($signed({1'b0, base, 16'h0}))
                             - 53'(stg_reg[ST_NUM-1].v2 >>> 12);
        stg_next[ST_NUM].p1t = p1_s * stg_reg[ST_NUM-1].t;

        stg_next[ST_DEN].n6 = 64'(stg_reg[ST_DEN-1].num) * 64'sd6250;
        stg_next[ST_DEN].d  = 48'($signed({1'b0, press_cal_1_reg, 16'h0}))
                            + 48'(stg_reg[ST_DEN-1].p1t >>> 15);

        stg_next[ST_MAG].neg = stg_reg[ST_MAG-1].n6[63] ^ stg_reg[ST_MAG-1].d[47];
        stg_next[ST_MAG].dz  = (stg_reg[ST_MAG-1].d == '0);
        stg_next[ST_MAG].an  = stg_reg[ST_MAG-1].n6[63] ? 64'(-stg_reg[ST_MAG-1].n6)
                                                        : 64'(stg_reg[ST_MAG-1].n6);
        stg_next[ST_MAG].ad  = stg_reg[ST_MAG-1].d[47] ? 48'(-stg_reg[ST_MAG-1].d)
                                                       : 48'(stg_reg[ST_MAG-1].d);

        // Quotient of an*2^16 / ad; integer part >= 2^20 saturates
        stg_next[ST_DINIT].sat = (stg_reg[ST_DINIT-1].an >> 20)
                               >= 64'(stg_reg[ST_DINIT-1].ad);
        stg_next[ST_DINIT].rem = 48'(stg_reg[ST_DINIT-1].an >> 20);
        stg_next[ST_DINIT].dvd = {stg_reg[ST_DINIT-1].an[19:0], 16'h0};
        stg_next[ST_DINIT].quo = '0;

        // Restoring divider, one bit a stage
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            trial = {stg_reg[ST_DIV0+j-1].rem, stg_reg[ST_DIV0+j-1].dvd[35]};
            stg_next[ST_DIV0+j].dvd = stg_reg[ST_DIV0+j-1].dvd << 1;
            if (trial >= {1'b0, stg_reg[ST_DIV0+j-1].ad})
            begin
                stg_next[ST_DIV0+j].rem = 48'(trial - {1'b0, stg_reg[ST_DIV0+j-1].ad});
                stg_next[ST_DIV0+j].quo = {stg_reg[ST_DIV0+j-1].quo[34:0], 1'b1};
            end
            else
            begin
                stg_next[ST_DIV0+j].rem = trial[47:0];
                stg_next[ST_DIV0+j].quo = {stg_reg[ST_DIV0+j-1].quo[34:0], 1'b0};
            end
        end

        mag = stg_reg[ST_P-1].sat ? 37'h10_0000_0000 : {1'b0, stg_reg[ST_P-1].quo};
        stg_next[ST_P].p = stg_reg[ST_P-1].neg ? -$signed({1'b0, mag})
                                               : $signed({1'b0, mag});

        q8   = 30'(stg_reg[ST_PSQ-1].p >>> 8);
        q_sq = q8 * q8;
        stg_next[ST_PSQ].qq  = q_sq[59:0];
        stg_next[ST_PSQ].pp8 = stg_reg[ST_PSQ-1].p * p8;

        s15 = 45'(stg_reg[ST_SP9-1].qq >> 15);
        stg_next[ST_SP9].sp9 = $signed({1'b0, s15}) * p9;

        stg_next[ST_W].w = 48'(stg_reg[ST_W-1].sp9 >>> 16)
                         + 48'(stg_reg[ST_W-1].pp8 >>> 15)
                         + (48'(p7) <<< 16);

        stg_next[ST_FIN].fin = 45'(stg_reg[ST_FIN-1].p) + 45'(stg_reg[ST_FIN-1].w >>> 4);

        rnd = 46'(stg_reg[ST_RES-1].fin) + RND_HALF;
        rs  = rnd >>> SH;
        priority if (stg_reg[ST_RES-1].dz)       stg_next[ST_RES].press = '0;
        else if (rs < 46'sd0)                    stg_next[ST_RES].press = '0;
        else if (rs > $signed({21'b0, PRESS_MAX})) stg_next[ST_RES].press = PRESS_MAX;
        else                                     stg_next[ST_RES].press = rs[24:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], sample_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NSTG; i++)
                stg_reg[i] <= stg_next[i];
        end
    end

    // ------------------------------------------------------ output and skid
    result_t out_reg, skid_reg, last_item;
    logic    out_vld_reg, skid_vld_reg, take;

    assign en   = !skid_vld_reg;
    assign take = out_vld_reg && !result_stall;

    assign last_item = '{celsius_centi:    stg_reg[NSTG-1].cc,
                         fahrenheit_centi: stg_reg[NSTG-1].fc,
                         pressure_pa_q8:   stg_reg[NSTG-1].press,
                         pressure_invalid: stg_reg[NSTG-1].dz};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (take)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end
        else if (!out_vld_reg || take)
            out_vld_reg <= vld_reg[NSTG-1];
        else if (vld_reg[NSTG-1])
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (!out_vld_reg || take)
            out_reg <= last_item;
        else
            skid_reg <= last_item;
    end

    assign sample_stall = skid_vld_reg;
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

@@ sv/bptc_checker.sv @@
// ============================================================================
// bptc_checker
// Port-level checks for the barometric compensation core, bound to the top.
// ============================================================================
module bptc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_stall,
    input logic              result_valid,
    input logic              result_stall,
    input bptc_pkg::result_t result
);
    import bptc_pkg::*;

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // skid only fills behind a stalled result
    a_skid: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_stall) |-> $past(result_valid && result_stall))
        else $error("input stall without stalled output");

    a_inval: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.pressure_invalid |-> result.pressure_pa_q8 == '0)
        else $error("invalid pressure not zero");

    a_crange: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.celsius_centi >= CELSIUS_MIN
                      && result.celsius_centi <= CELSIUS_MAX)
        else $error("celsius out of range");

endmodule

bind baro_temp_pressure_compensation_core bptc_checker u_bptc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
